// File: rtl/strtol_pkg.sv
// ----------------------------------------------------------------------------
// strtol_pkg
// Shared constants, status codes and character helpers for the
// string-to-integer converter.
// ----------------------------------------------------------------------------
`default_nettype none

package strtol_pkg;

  localparam int SYMBOL_W = 8;
  localparam int RADIX_W  = 6;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int MAG_W    = VALUE_W - 1;
  localparam int DIGIT_W  = 6;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [DIGIT_W-1:0] NOT_DIGIT   = DIGIT_W'(36);

  localparam logic [SYMBOL_W-1:0] CH_NUL   = 8'h00;
  localparam logic [SYMBOL_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYMBOL_W-1:0] CH_TAB   = 8'h09;
  localparam logic [SYMBOL_W-1:0] CH_CR    = 8'h0d;
  localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [SYMBOL_W-1:0] CH_0     = 8'h30;
  localparam logic [SYMBOL_W-1:0] CH_9     = 8'h39;
  localparam logic [SYMBOL_W-1:0] CH_LA    = 8'h61;
  localparam logic [SYMBOL_W-1:0] CH_LZ    = 8'h7a;
  localparam logic [SYMBOL_W-1:0] CH_UA    = 8'h41;
  localparam logic [SYMBOL_W-1:0] CH_UZ    = 8'h5a;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_BASE = 2'd2;

  localparam logic [VALUE_W-1:0] VALUE_POS_SAT = {1'b0, {MAG_W{1'b1}}};
  localparam logic [VALUE_W-1:0] VALUE_NEG_SAT = {1'b1, {MAG_W{1'b0}}};

  function automatic logic is_space(input logic [SYMBOL_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_value(input logic [SYMBOL_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    if (c >= CH_0 && c <= CH_9) begin
      d = DIGIT_W'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = DIGIT_W'(c - CH_LA) + DIGIT_W'(10);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = DIGIT_W'(c - CH_UA) + DIGIT_W'(10);
    end else begin
      d = NOT_DIGIT;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: rtl/string_to_integer_any_base.sv
// ----------------------------------------------------------------------------
// string_to_integer_any_base
// Streaming strtol-style converter: one string byte per transaction, one
// signed 64-bit result with status on the terminating NUL byte.
// ----------------------------------------------------------------------------
// Accepts one byte per clock cycle, back to back, except while a NUL byte
// waits in the input register for the previous result to be taken. There
// a single 63x6-bit multiply-add with an overflow check updates the running
// magnitude; that update is what limits the rate to one byte per cycle. The
// result is loaded into the output register as its NUL byte leaves the input
// register and holds until taken; bytes up to the next NUL keep flowing in.
// The base is sampled with each byte; write it only while the block is idle.
`default_nettype none

module string_to_integer_any_base (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 radix_wr_en,
  input  wire logic [strtol_pkg::RADIX_W-1:0]       radix_wr_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [strtol_pkg::SYMBOL_W-1:0]      symbol,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [strtol_pkg::VALUE_W-1:0]     value,
  output logic [strtol_pkg::STATUS_W-1:0]           status
);

  import strtol_pkg::*;

  localparam int MUL_W = MAG_W + RADIX_W;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_SIGN,
    PH_DIGITS,
    PH_STOPPED
  } phase_t;

  logic [RADIX_W-1:0]  radix;
  logic                s1_valid;
  logic [SYMBOL_W-1:0] s1_symbol;
  logic [RADIX_W-1:0]  s1_radix;

  phase_t              phase, phase_next;
  logic                is_negative, is_negative_next;
  logic [MAG_W-1:0]    magnitude, magnitude_next;
  logic                overflowed, overflowed_next;

  logic                s1_end, s1_advance, base_ok, alnum;
  logic [DIGIT_W-1:0]  dig;
  logic [MUL_W-1:0]    prod;
  logic                prod_ovf;
  logic [VALUE_W-1:0]  result_value;
  logic [STATUS_W-1:0] result_status;

  assign s1_end     = (s1_symbol == CH_NUL);
  assign s1_advance = s1_valid && (!s1_end || !out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign base_ok    = (s1_radix >= RADIX_MIN) && (s1_radix <= RADIX_MAX);
  assign dig        = digit_value(s1_symbol);
  assign alnum      = (dig != NOT_DIGIT);
  assign prod       = MUL_W'(magnitude) * MUL_W'(s1_radix) + MUL_W'(dig);
  assign prod_ovf   = (prod[MUL_W-1:MAG_W] != '0);

  always_comb begin
    phase_next       = phase;
    is_negative_next = is_negative;
    magnitude_next   = magnitude;
    overflowed_next  = overflowed;
    if (s1_advance) begin
      if (s1_end) begin
        phase_next       = PH_SKIP;
        is_negative_next = 1'b0;
        magnitude_next   = '0;
        overflowed_next  = 1'b0;
      end else if (base_ok) begin
        unique case (phase)
          PH_SKIP: begin
            if (is_space(s1_symbol)) begin
              phase_next = PH_SKIP;
            end else if (s1_symbol == CH_MINUS) begin
              is_negative_next = 1'b1;
              phase_next       = PH_SIGN;
            end else if (s1_symbol == CH_PLUS) begin
              phase_next = PH_SIGN;
            end else if (!alnum) begin
              phase_next = PH_STOPPED;
            end else if (dig >= s1_radix) begin
              phase_next = PH_STOPPED;
            end else if (prod_ovf) begin
              overflowed_next = 1'b1;
              phase_next      = PH_STOPPED;
            end else begin
              magnitude_next = prod[MAG_W-1:0];
              phase_next     = PH_DIGITS;
            end
          end
          PH_SIGN, PH_DIGITS: begin
            if (!alnum && phase == PH_SIGN) begin
              is_negative_next = 1'b0;
              phase_next       = PH_STOPPED;
            end else if (dig >= s1_radix) begin
              phase_next = PH_STOPPED;
            end else if (prod_ovf) begin
              overflowed_next = 1'b1;
              phase_next      = PH_STOPPED;
            end else begin
              magnitude_next = prod[MAG_W-1:0];
              phase_next     = PH_DIGITS;
            end
          end
          PH_STOPPED: begin
            phase_next = PH_STOPPED;
          end
          default: begin
            phase_next = PH_STOPPED;
          end
        endcase
      end
    end
  end

  always_comb begin
    if (!base_ok) begin
      result_value  = '0;
      result_status = ST_BAD_BASE;
    end else if (overflowed) begin
      result_value  = is_negative ? VALUE_NEG_SAT : VALUE_POS_SAT;
      result_status = ST_RANGE;
    end else begin
      result_value  = is_negative ? (VALUE_W'(0) - VALUE_W'(magnitude)) : VALUE_W'(magnitude);
      result_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= RADIX_RESET;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      phase       <= PH_SKIP;
      is_negative <= 1'b0;
      magnitude   <= '0;
      overflowed  <= 1'b0;
    end else begin
      if (radix_wr_en) begin
        radix <= radix_wr_data;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_advance && s1_end) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      phase       <= phase_next;
      is_negative <= is_negative_next;
      magnitude   <= magnitude_next;
      overflowed  <= overflowed_next;
    end
    if (in_ready && in_valid) begin
      s1_symbol <= symbol;
      s1_radix  <= radix;
    end
    if (s1_advance && s1_end) begin
      value  <= result_value;
      status <= result_status;
    end
  end

  // checks
  a_bad_base_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_BAD_BASE |-> value == '0)
    else $error("invalid base result not zero");

  a_range_saturated: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_RANGE |-> value == VALUE_POS_SAT || value == VALUE_NEG_SAT)
    else $error("range error without saturated value");

  a_skip_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> magnitude == '0 && !overflowed && !is_negative)
    else $error("leftover state while skipping whitespace");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    s1_advance && s1_end |=> phase == PH_SKIP && out_valid)
    else $error("end of string did not clear state and post result");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for string_to_integer_any_base. Strings are streamed a
// byte per transaction under random idling on both channels; a directed
// table comes first, then mostly well-formed random numbers with noise and
// broken signs mixed in. The base is changed between strings and, now and
// then, mid-string. Each result is checked against the table or a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import strtol_pkg::*;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;
  } conv_result_t;

  typedef struct {
    logic [RADIX_W-1:0] base;
    string              text;
    bit                 typed;
    conv_result_t       want;
  } vector_t;

  typedef enum logic [1:0] {SCAN_BLANKS, AFTER_SIGN, IN_DIGITS, HALTED} conv_phase_t;

  localparam logic [VALUE_W-1:0] MAG_LIMIT = {1'b0, {MAG_W{1'b1}}};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  radix_wr_en = 1'b0;
  logic [RADIX_W-1:0]    radix_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SYMBOL_W-1:0]   symbol = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [VALUE_W-1:0] value;
  logic [STATUS_W-1:0]   status;

  // predictor state
  logic [RADIX_W-1:0] base_now = RADIX_RESET;
  conv_phase_t        phase_now = SCAN_BLANKS;
  bit                 negative_now = 1'b0;
  logic [MAG_W-1:0]   mag_now = '0;
  bit                 ovf_now = 1'b0;

  conv_result_t expected[$];
  vector_t      vectors[$];
  bit           quiet = 1'b0;
  int           errors = 0;
  int           bytes_counted = 0;
  int           strings_sent = 0;
  int           results_checked = 0;
  int           radix_writes = 0;
  bit [63:0]    bases_seen = 64'd1 << 10;

  string_to_integer_any_base uut (
    .clk           (clk),
    .rst           (rst),
    .radix_wr_en   (radix_wr_en),
    .radix_wr_data (radix_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .symbol        (symbol),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .value         (value),
    .status        (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
    errors++;
  endtask

  function automatic logic [DIGIT_W-1:0] weight_of(input logic [SYMBOL_W-1:0] c);
    if (c >= CH_0 && c <= CH_9) begin
      return DIGIT_W'(c - CH_0);
    end
    if (c >= CH_LA && c <= CH_LZ) begin
      return DIGIT_W'(c - CH_LA + 8'd10);
    end
    if (c >= CH_UA && c <= CH_UZ) begin
      return DIGIT_W'(c - CH_UA + 8'd10);
    end
    return NOT_DIGIT;
  endfunction

  function automatic bit is_blank(input logic [SYMBOL_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [SYMBOL_W-1:0] digit_char(input int d, input bit upper);
    if (d < 10) begin
      return CH_0 + SYMBOL_W'(d);
    end
    return (upper ? CH_UA : CH_LA) + SYMBOL_W'(d - 10);
  endfunction

  function automatic logic [SYMBOL_W-1:0] pick_blank();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? CH_SPACE : CH_TAB + SYMBOL_W'(r);
  endfunction

  function automatic bit base_valid();
    return base_now >= RADIX_MIN && base_now <= RADIX_MAX;
  endfunction

  task automatic accept_digit(input logic [SYMBOL_W-1:0] c);
    logic [63:0] w;
    logic [63:0] ceiling;
    w = 64'(weight_of(c));
    if (w >= 64'(base_now)) begin
      phase_now = HALTED;
    end else begin
      ceiling = (MAG_LIMIT - w) / 64'(base_now);
      if ({1'b0, mag_now} > ceiling) begin
        ovf_now = 1'b1;
        phase_now = HALTED;
      end else begin
        mag_now = MAG_W'({1'b0, mag_now} * 64'(base_now) + w);
        phase_now = IN_DIGITS;
      end
    end
  endtask

  task automatic predict_symbol(input logic [SYMBOL_W-1:0] c, output bit made,
                                output conv_result_t r);
    made = 1'b0;
    r = '0;
    if (c == CH_NUL) begin
      made = 1'b1;
      if (!base_valid()) begin
        r.status = ST_BAD_BASE;
      end else if (ovf_now) begin
        r.value  = negative_now ? VALUE_NEG_SAT : VALUE_POS_SAT;
        r.status = ST_RANGE;
      end else begin
        r.value  = negative_now ? -{1'b0, mag_now} : {1'b0, mag_now};
        r.status = ST_OK;
      end
      phase_now = SCAN_BLANKS;
      negative_now = 1'b0;
      mag_now = '0;
      ovf_now = 1'b0;
    end else if (base_valid()) begin
      case (phase_now)
        SCAN_BLANKS: begin
          if (is_blank(c)) begin
          end else if (c == CH_MINUS) begin
            negative_now = 1'b1;
            phase_now = AFTER_SIGN;
          end else if (c == CH_PLUS) begin
            phase_now = AFTER_SIGN;
          end else if (weight_of(c) != NOT_DIGIT) begin
            accept_digit(c);
          end else begin
            phase_now = HALTED;
          end
        end
        AFTER_SIGN: begin
          if (weight_of(c) != NOT_DIGIT) begin
            accept_digit(c);
          end else begin
            negative_now = 1'b0;
            phase_now = HALTED;
          end
        end
        IN_DIGITS: begin
          accept_digit(c);
        end
        default: begin
          phase_now = HALTED;
        end
      endcase
    end
  endtask

  // called just after a rising edge; leaves valid high after the transaction
  task automatic send_symbol(input logic [SYMBOL_W-1:0] s, input bit typed = 1'b0,
                             input conv_result_t want = '0);
    bit           made;
    conv_result_t r;
    while (!quiet && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    symbol <= s;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    if (base_valid() || s == CH_NUL) begin
      bytes_counted++;
    end
    predict_symbol(s, made, r);
    if (made) begin
      expected.push_back(typed ? want : r);
      strings_sent++;
    end
  endtask

  // the sender holds off until every result is in and the pipeline is empty
  task automatic set_radix(input logic [RADIX_W-1:0] r);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    radix_wr_en <= 1'b1;
    radix_wr_data <= r;
    @(posedge clk);
    radix_wr_en <= 1'b0;
    base_now = r;
    bases_seen[r] = 1'b1;
    radix_writes++;
  endtask

  task automatic send_random_string();
    int kind;
    int n;
    int top;
    kind = $urandom_range(99);
    if (kind < 75) begin
      n = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 3);
      repeat (n) send_symbol(pick_blank());
      case ($urandom_range(2))
        1: send_symbol(CH_PLUS);
        2: send_symbol(CH_MINUS);
        default: begin
        end
      endcase
      if ($urandom_range(99) < 3) begin
        set_radix(RADIX_W'($urandom_range(2, 36)));
      end
      top = base_valid() ? int'(base_now) - 1 : 35;
      n = ($urandom_range(9) == 0) ? $urandom_range(12, 70) : $urandom_range(1, 8);
      repeat (n) send_symbol(digit_char($urandom_range(top), 1'($urandom_range(1))));
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 3)) send_symbol(SYMBOL_W'($urandom_range(1, 255)));
      end
    end else if (kind < 90) begin
      repeat ($urandom_range(6)) send_symbol(SYMBOL_W'($urandom_range(1, 255)));
    end else begin
      send_symbol($urandom_range(1) ? CH_PLUS : CH_MINUS);
      case ($urandom_range(3))
        1: send_symbol($urandom_range(1) ? CH_PLUS : CH_MINUS);
        2: send_symbol(pick_blank());
        3: send_symbol(SYMBOL_W'($urandom_range(128, 255)));
        default: begin
        end
      endcase
      if ($urandom_range(1)) begin
        send_symbol(digit_char($urandom_range(9), 1'b0));
      end
    end
    send_symbol(CH_NUL);
  endtask

  task automatic add_vector(input logic [RADIX_W-1:0] b, input string t, input bit typed,
                            input logic [63:0] v = '0, input logic [STATUS_W-1:0] st = ST_OK);
    vector_t row;
    row.base  = b;
    row.text  = t;
    row.typed = typed;
    row.want  = '{value: v, status: st};
    vectors.push_back(row);
  endtask

  // result side: random stalls, compare each transaction with the oldest prediction
  always @(posedge clk) begin
    conv_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected.size() == 0) begin
          report_mismatch("unexpected result", '0, value);
        end else begin
          want = expected.pop_front();
          if (value !== want.value) begin
            report_mismatch("value", want.value, value);
          end
          if (status !== want.status) begin
            report_mismatch("status", 64'(want.status), 64'(status));
          end
          results_checked++;
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 24);
    end
  end

  initial begin
    int guard;
    add_vector(10, "", 1'b1, 0, ST_OK);
    add_vector(10, "\040\011\012\013\014\015123", 1'b1, 123, ST_OK);
    add_vector(10, "-42", 1'b1, -42, ST_OK);
    add_vector(10, "+7x9", 1'b1, 7, ST_OK);
    add_vector(10, "- 5", 1'b1, 0, ST_OK);
    add_vector(10, "+", 1'b1, 0, ST_OK);
    add_vector(10, "--5", 1'b1, 0, ST_OK);
    add_vector(10, "\3771", 1'b1, 0, ST_OK);
    add_vector(10, "12\2003", 1'b1, 12, ST_OK);
    add_vector(36, "zzzzzzzzzzzzzzz", 1'b1, VALUE_POS_SAT, ST_RANGE);
    add_vector(36, "-zzzzzzzzzzzzzz", 1'b1, VALUE_NEG_SAT, ST_RANGE);
    add_vector(36, "Zz+A", 1'b0);
    add_vector(16, "7fffffffffffffff", 1'b1, VALUE_POS_SAT, ST_OK);
    add_vector(16, "-8000000000000000", 1'b1, VALUE_NEG_SAT, ST_RANGE);
    add_vector(16, "-7FFFFFFFFFFFFFFF", 1'b1, 64'h8000000000000001, ST_OK);
    add_vector(2, "1012", 1'b1, 5, ST_OK);
    add_vector(0, "123", 1'b1, 0, ST_BAD_BASE);
    add_vector(1, "1", 1'b1, 0, ST_BAD_BASE);
    add_vector(37, "z", 1'b1, 0, ST_BAD_BASE);
    add_vector(63, "9", 1'b1, 0, ST_BAD_BASE);
    add_vector(8, "\011-0777", 1'b0);
    add_vector(10, "99", 1'b0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (vectors[i]) begin
      if (vectors[i].base != base_now) begin
        set_radix(vectors[i].base);
      end
      for (int k = 0; k < vectors[i].text.len(); k++) begin
        send_symbol(vectors[i].text[k]);
      end
      send_symbol(CH_NUL, vectors[i].typed, vectors[i].want);
    end

    // base changed part way through a number
    send_symbol(CH_0 + 8'd1);
    send_symbol(CH_0 + 8'd2);
    set_radix(16);
    send_symbol(CH_LA);
    send_symbol(CH_NUL);

    bytes_counted = 0;
    while (bytes_counted < 1800) begin
      quiet = bytes_counted >= 700 && bytes_counted < 1000;
      if ($urandom_range(99) < 8) begin
        case ($urandom_range(9))
          0: set_radix($urandom_range(1) ? RADIX_W'($urandom_range(1))
                                         : RADIX_W'($urandom_range(37, 63)));
          1: set_radix(RADIX_MIN);
          2: set_radix(RADIX_MAX);
          default: set_radix(RADIX_W'($urandom_range(2, 36)));
        endcase
      end
      send_random_string();
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    guard = 0;
    while (expected.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (expected.size() != 0) begin
      $display("%0d results never arrived", expected.size());
      errors++;
    end

    $display("streamed %0d strings over %0d bases with %0d base writes",
             strings_sent, $countones(bases_seen), radix_writes);
    $display("%0d results compared, %0d mismatches", results_checked, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/strtol_pkg.sv
rtl/string_to_integer_any_base.sv
bench/testbench.sv
